>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files of the safety stop monitor.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/dssm_pkg.sv
// Types and constants of the drive safety stop monitor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dssm_pkg;

   typedef enum logic [2:0] {
      CAUSE_NONE     = 3'd0,
      CAUSE_TIME     = 3'd1,
      CAUSE_STALL    = 3'd2,
      CAUSE_OBSTACLE = 3'd3,
      CAUSE_TRACK    = 3'd4
   } cause_type;

   // csr register indexes
   localparam logic [1:0] CSR_RUN_TIME_LIMIT     = 2'd0;
   localparam logic [1:0] CSR_OBSTACLE_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_TRACK_CHECK_ENABLE = 2'd2;

   localparam logic [15:0]        TIME_LIMIT_MAX  = 16'd30000;
   localparam logic [15:0]        TIMER_TOP       = 16'hFFFF;
   localparam logic [15:0]        STALL_ARM_TICKS = 16'd1000;
   localparam logic signed [15:0] STALL_DRIVE_POS = 16'sd1000;
   localparam logic signed [15:0] STALL_DRIVE_NEG = -16'sd1000;
   localparam logic [7:0]         STALL_TRIP      = 8'd200;
   localparam logic [6:0]         NEAR_TRIP       = 7'd100;
   localparam logic [6:0]         TRACK_TRIP      = 7'd100;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] left_wheel_speed;
      logic signed [15:0] right_wheel_speed;
      logic signed [15:0] left_drive;
      logic signed [15:0] right_drive;
      logic [15:0]        range_mm;
      logic               lost_track;
      logic               on_zebra;
   } req_item_type;

   typedef struct packed {
      logic        running;
      cause_type   stop_cause;
      logic        stopped_now;
      logic        alarm;
      logic [15:0] elapsed_ticks;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] run_time_limit;
      logic [15:0] obstacle_threshold_mm;
      logic        track_check_enable;
   } cfg_type;

   typedef struct packed {
      logic        run_flag;
      logic [15:0] run_timer;
      logic [7:0]  stall_counter;
      logic [6:0]  obstacle_counter;
      logic [6:0]  track_counter;
      cause_type   cause_latch;
   } state_type;

endpackage

`default_nettype wire

>>> rtl/dssm_in_stage.sv
// Input register of the safety stop monitor: holds one request beat.
// Depends on dssm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dssm_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire dssm_pkg::req_item_type req_item,
   input  wire logic                  take,
   output logic                       item_valid,
   output dssm_pkg::req_item_type     item
);
   import dssm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // slot frees up when the held beat moves on this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

>>> rtl/dssm_step.sv
// Per-tick update of run state, run timer, fault counters and stop cause.
// Depends on dssm_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module dssm_step (
   input  wire dssm_pkg::req_item_type item,
   input  wire dssm_pkg::state_type    cur,
   input  wire dssm_pkg::cfg_type      cfg,
   output dssm_pkg::state_type         nxt,
   output dssm_pkg::rsp_item_type      rsp
);
   import dssm_pkg::*;

   logic [15:0] timer_inc;
   logic        limit_on;
   logic        timed;
   logic [15:0] timer_tick;
   logic        stall_armed;
   logic        left_stall;
   logic        right_stall;
   logic        stall;
   logic [7:0]  stall_up;
   logic        stall_trip;
   logic [7:0]  stall_tick;
   logic        near;
   logic [6:0]  obs_up;
   logic        obs_trip;
   logic [6:0]  obs_tick;
   logic        lost;
   logic [6:0]  trk_up;
   logic        trk_trip;
   logic [6:0]  trk_tick;
   logic        any_stop;
   cause_type   cause_tick;

   assign timer_inc  = (cur.run_timer != TIMER_TOP) ? cur.run_timer + 16'd1 : cur.run_timer;
   assign limit_on   = (cfg.run_time_limit != 16'd0) && (cfg.run_time_limit < TIME_LIMIT_MAX);
   assign timed      = limit_on && (timer_inc > cfg.run_time_limit);
   assign timer_tick = timed ? 16'd0 : timer_inc;

   // stalled wheel: not moving forward while driven hard either way
   assign stall_armed = (timer_tick > STALL_ARM_TICKS) && !item.on_zebra;
   assign left_stall  = (item.left_wheel_speed < 16'sd1) &&
                        ((item.left_drive > STALL_DRIVE_POS) ||
                         (item.left_drive < STALL_DRIVE_NEG));
   assign right_stall = (item.right_wheel_speed < 16'sd1) &&
                        ((item.right_drive > STALL_DRIVE_POS) ||
                         (item.right_drive < STALL_DRIVE_NEG));
   assign stall       = left_stall || right_stall;
   assign stall_up    = cur.stall_counter + 8'd1;
   assign stall_trip  = stall_armed && stall && (stall_up > STALL_TRIP);

   always_comb begin
      if (!stall_armed) begin
         stall_tick = cur.stall_counter;
      end else if (stall) begin
         stall_tick = stall_trip ? 8'd0 : stall_up;
      end else if (cur.stall_counter != 8'd0) begin
         stall_tick = cur.stall_counter - 8'd1;
      end else begin
         stall_tick = cur.stall_counter;
      end
   end

   assign near     = item.range_mm < cfg.obstacle_threshold_mm;
   assign obs_up   = cur.obstacle_counter + 7'd1;
   assign obs_trip = near && (obs_up > NEAR_TRIP);

   always_comb begin
      if (near) begin
         obs_tick = obs_trip ? 7'd0 : obs_up;
      end else if (cur.obstacle_counter != 7'd0) begin
         obs_tick = cur.obstacle_counter - 7'd1;
      end else begin
         obs_tick = cur.obstacle_counter;
      end
   end

   assign lost     = cfg.track_check_enable && item.lost_track;
   assign trk_up   = cur.track_counter + 7'd1;
   assign trk_trip = lost && (trk_up > TRACK_TRIP);

   always_comb begin
      if (!cfg.track_check_enable) begin
         trk_tick = cur.track_counter;
      end else if (lost) begin
         trk_tick = trk_trip ? 7'd0 : trk_up;
      end else if (cur.track_counter != 7'd0) begin
         trk_tick = cur.track_counter - 7'd1;
      end else begin
         trk_tick = cur.track_counter;
      end
   end

   assign any_stop = timed || stall_trip || obs_trip || trk_trip;

   // first cause in check order wins, and only if none is latched yet
   always_comb begin
      if (cur.cause_latch != CAUSE_NONE) begin
         cause_tick = cur.cause_latch;
      end else if (timed) begin
         cause_tick = CAUSE_TIME;
      end else if (stall_trip) begin
         cause_tick = CAUSE_STALL;
      end else if (obs_trip) begin
         cause_tick = CAUSE_OBSTACLE;
      end else if (trk_trip) begin
         cause_tick = CAUSE_TRACK;
      end else begin
         cause_tick = CAUSE_NONE;
      end
   end

   always_comb begin
      nxt             = cur;
      rsp.stopped_now = 1'b0;
      rsp.alarm       = 1'b0;
      if (item.cmd) begin
         nxt.run_flag    = 1'b1;
         nxt.run_timer   = 16'd0;
         nxt.cause_latch = CAUSE_NONE;
      end else if (cur.run_flag) begin
         nxt.run_flag         = !any_stop;
         nxt.run_timer        = timer_tick;
         nxt.stall_counter    = stall_tick;
         nxt.obstacle_counter = obs_tick;
         nxt.track_counter    = trk_tick;
         nxt.cause_latch      = cause_tick;
         rsp.stopped_now      = any_stop;
         rsp.alarm            = stall_trip || obs_trip || trk_trip;
      end
      rsp.running       = nxt.run_flag;
      rsp.stop_cause    = nxt.cause_latch;
      rsp.elapsed_ticks = nxt.run_timer;
   end

endmodule

`default_nettype wire

>>> rtl/dssm_out_stage.sv
// Result register of the safety stop monitor: holds one response beat.
// Depends on dssm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dssm_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire dssm_pkg::rsp_item_type load_item,
   output logic                       can_load,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output dssm_pkg::rsp_item_type     rsp_item
);
   import dssm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

>>> rtl/drive_safety_stop_monitor.sv
// Drive safety stop monitor, top level.
// A request beat passes the input register, then the result register, before rsp_valid rises.
// Throughput: 1 beat per cycle while rsp_ready holds no beat back; the tick state updates
// as a beat moves from the input to the result register, so the next beat sees it without a bubble.
// Reset (synchronous, active high) clears run state, counters, cause, csr regs
// and both stage valids. Depends on dssm_pkg, dssm_in_stage, dssm_step, dssm_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module drive_safety_stop_monitor (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic signed [15:0] req_left_wheel_speed,
   input  wire logic signed [15:0] req_right_wheel_speed,
   input  wire logic signed [15:0] req_left_drive,
   input  wire logic signed [15:0] req_right_drive,
   input  wire logic [15:0]        req_range_mm,
   input  wire logic               req_lost_track,
   input  wire logic               req_on_zebra,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_running,
   output logic [2:0]              rsp_stop_cause,
   output logic                    rsp_stopped_now,
   output logic                    rsp_alarm,
   output logic [15:0]             rsp_elapsed_ticks,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import dssm_pkg::*;

   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         can_load;
   logic         advance;
   state_type    state_ff;
   state_type    state_in;
   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   rsp_item_type step_rsp;
   rsp_item_type rsp_item;

   assign req_item.cmd               = req_cmd;
   assign req_item.left_wheel_speed  = req_left_wheel_speed;
   assign req_item.right_wheel_speed = req_right_wheel_speed;
   assign req_item.left_drive        = req_left_drive;
   assign req_item.right_drive       = req_right_drive;
   assign req_item.range_mm          = req_range_mm;
   assign req_item.lost_track        = req_lost_track;
   assign req_item.on_zebra          = req_on_zebra;

   dssm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (can_load),
      .item_valid (item_valid),
      .item       (item)
   );

   dssm_step u_step (
      .item (item),
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .nxt  (state_in),
      .rsp  (step_rsp)
   );

   // a held beat is processed exactly when its result can be registered
   assign advance = item_valid && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RUN_TIME_LIMIT:     cfg_in.run_time_limit        = csr_wdata;
            CSR_OBSTACLE_THRESHOLD: cfg_in.obstacle_threshold_mm = csr_wdata;
            CSR_TRACK_CHECK_ENABLE: cfg_in.track_check_enable    = csr_wdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dssm_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_item (step_rsp),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_running       = rsp_item.running;
   assign rsp_stop_cause    = rsp_item.stop_cause;
   assign rsp_stopped_now   = rsp_item.stopped_now;
   assign rsp_alarm         = rsp_item.alarm;
   assign rsp_elapsed_ticks = rsp_item.elapsed_ticks;

endmodule

`default_nettype wire

>>> rtl/dssm_checker.sv
// Port-level checks of the drive safety stop monitor, bound to the top level.
// Depends on dssm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dssm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_running,
   input wire logic [2:0]  rsp_stop_cause,
   input wire logic        rsp_stopped_now,
   input wire logic        rsp_alarm,
   input wire logic [15:0] rsp_elapsed_ticks
);
   import dssm_pkg::*;

   // a stalled response beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_stop_cause) && $stable(rsp_elapsed_ticks))

   // a stop in this beat leaves the vehicle stopped with a cause latched
   `ASSERT_IMPLIES(a_stop_has_cause, clock, reset, rsp_valid && rsp_stopped_now, !rsp_running && rsp_stop_cause != CAUSE_NONE)

   // a counter trip always stops the vehicle
   `ASSERT_IMPLIES(a_alarm_stops, clock, reset, rsp_valid && rsp_alarm, !rsp_running)

   // start clears the cause and only a stop sets it, so a running vehicle has none
   `ASSERT_IMPLIES(a_run_no_cause, clock, reset, rsp_valid && rsp_running, rsp_stop_cause == CAUSE_NONE)

endmodule

bind drive_safety_stop_monitor dssm_checker u_dssm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_running       (rsp_running),
   .rsp_stop_cause    (rsp_stop_cause),
   .rsp_stopped_now   (rsp_stopped_now),
   .rsp_alarm         (rsp_alarm),
   .rsp_elapsed_ticks (rsp_elapsed_ticks)
);

`default_nettype wire

>>> test/stop_monitor_checker.sv
// Checker for the drive safety stop monitor: mirrors csr writes, predicts the
// status beat for every request beat and compares it with the response channel.
// Depends on dssm_pkg.
`timescale 1ns / 1ps

module stop_monitor_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_cmd,
   input  logic signed [15:0] req_left_wheel_speed,
   input  logic signed [15:0] req_right_wheel_speed,
   input  logic signed [15:0] req_left_drive,
   input  logic signed [15:0] req_right_drive,
   input  logic [15:0]        req_range_mm,
   input  logic               req_lost_track,
   input  logic               req_on_zebra,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_running,
   input  logic [2:0]         rsp_stop_cause,
   input  logic               rsp_stopped_now,
   input  logic               rsp_alarm,
   input  logic [15:0]        rsp_elapsed_ticks,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output int                 errors,
   output int                 pending
);
   import dssm_pkg::*;

   state_type    mon;
   cfg_type      cfg;
   rsp_item_type expected_status[$];
   rsp_item_type want;
   req_item_type item;

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want_v);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want_v);
      errors++;
   endtask

   // stop the vehicle; only the first cause since the last start is kept
   function automatic void halt_run(cause_type why);
      mon.run_flag = 1'b0;
      if (mon.cause_latch == CAUSE_NONE)
         mon.cause_latch = why;
   endfunction

   function automatic rsp_item_type step_monitor(req_item_type it);
      int           l_speed, r_speed, l_drive, r_drive;
      logic         was_running, tripped, stalled;
      rsp_item_type r;
      l_speed = $signed(it.left_wheel_speed);
      r_speed = $signed(it.right_wheel_speed);
      l_drive = $signed(it.left_drive);
      r_drive = $signed(it.right_drive);
      was_running = mon.run_flag;
      tripped = 1'b0;
      if (it.cmd) begin
         mon.run_flag = 1'b1;
         mon.run_timer = '0;
         mon.cause_latch = CAUSE_NONE;
         was_running = 1'b0;
      end else if (mon.run_flag) begin
         if (mon.run_timer != TIMER_TOP)
            mon.run_timer = mon.run_timer + 16'd1;
         if (cfg.run_time_limit != 16'd0 && cfg.run_time_limit < TIME_LIMIT_MAX &&
             mon.run_timer > cfg.run_time_limit) begin
            mon.run_timer = '0;
            halt_run(CAUSE_TIME);
         end
         if (mon.run_timer > STALL_ARM_TICKS && !it.on_zebra) begin
            stalled = (l_speed < 1 && (l_drive > STALL_DRIVE_POS || l_drive < STALL_DRIVE_NEG)) ||
                      (r_speed < 1 && (r_drive > STALL_DRIVE_POS || r_drive < STALL_DRIVE_NEG));
            if (stalled) begin
               mon.stall_counter = mon.stall_counter + 8'd1;
               if (mon.stall_counter > STALL_TRIP) begin
                  mon.stall_counter = '0;
                  tripped = 1'b1;
                  halt_run(CAUSE_STALL);
               end
            end else if (mon.stall_counter != 8'd0) begin
               mon.stall_counter = mon.stall_counter - 8'd1;
            end
         end
         if (it.range_mm < cfg.obstacle_threshold_mm) begin
            mon.obstacle_counter = mon.obstacle_counter + 7'd1;
            if (mon.obstacle_counter > NEAR_TRIP) begin
               mon.obstacle_counter = '0;
               tripped = 1'b1;
               halt_run(CAUSE_OBSTACLE);
            end
         end else if (mon.obstacle_counter != 7'd0) begin
            mon.obstacle_counter = mon.obstacle_counter - 7'd1;
         end
         if (cfg.track_check_enable) begin
            if (it.lost_track) begin
               mon.track_counter = mon.track_counter + 7'd1;
               if (mon.track_counter > TRACK_TRIP) begin
                  mon.track_counter = '0;
                  tripped = 1'b1;
                  halt_run(CAUSE_TRACK);
               end
            end else if (mon.track_counter != 7'd0) begin
               mon.track_counter = mon.track_counter - 7'd1;
            end
         end
      end
      r.running = mon.run_flag;
      r.stop_cause = mon.cause_latch;
      r.stopped_now = was_running && !mon.run_flag;
      r.alarm = tripped;
      r.elapsed_ticks = mon.run_timer;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mon = '0;
         cfg = '0;
         expected_status.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RUN_TIME_LIMIT:     cfg.run_time_limit = csr_wdata;
               CSR_OBSTACLE_THRESHOLD: cfg.obstacle_threshold_mm = csr_wdata;
               CSR_TRACK_CHECK_ENABLE: cfg.track_check_enable = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               report_mismatch("status beat with nothing outstanding, ticks",
                               rsp_elapsed_ticks, 16'd0);
            end else begin
               want = expected_status.pop_front();
               if (rsp_running !== want.running)
                  report_mismatch("running", rsp_running, want.running);
               if (rsp_stop_cause !== want.stop_cause)
                  report_mismatch("stop_cause", rsp_stop_cause, want.stop_cause);
               if (rsp_stopped_now !== want.stopped_now)
                  report_mismatch("stopped_now", rsp_stopped_now, want.stopped_now);
               if (rsp_alarm !== want.alarm)
                  report_mismatch("alarm", rsp_alarm, want.alarm);
               if (rsp_elapsed_ticks !== want.elapsed_ticks)
                  report_mismatch("elapsed_ticks", rsp_elapsed_ticks, want.elapsed_ticks);
            end
         end
         if (req_valid && req_ready) begin
            item.cmd = req_cmd;
            item.left_wheel_speed = req_left_wheel_speed;
            item.right_wheel_speed = req_right_wheel_speed;
            item.left_drive = req_left_drive;
            item.right_drive = req_right_drive;
            item.range_mm = req_range_mm;
            item.lost_track = req_lost_track;
            item.on_zebra = req_on_zebra;
            expected_status.push_back(step_monitor(item));
         end
      end
      pending = expected_status.size();
   end

endmodule

>>> test/drive_safety_stop_monitor_tb.sv
// Top of the stop monitor testbench: clock, reset, stimulus, csr writes and verdict.
// Depends on dssm_pkg, drive_safety_stop_monitor and stop_monitor_checker.
`timescale 1ns / 1ps

module drive_safety_stop_monitor_tb;
   import dssm_pkg::*;

   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int         QUIET_LIMIT = 4000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cmd = 1'b0;
   logic signed [15:0] req_left_wheel_speed = '0;
   logic signed [15:0] req_right_wheel_speed = '0;
   logic signed [15:0] req_left_drive = '0;
   logic signed [15:0] req_right_drive = '0;
   logic [15:0]        req_range_mm = '0;
   logic               req_lost_track = 1'b0;
   logic               req_on_zebra = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_running;
   logic [2:0]         rsp_stop_cause;
   logic               rsp_stopped_now;
   logic               rsp_alarm;
   logic [15:0]        rsp_elapsed_ticks;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;
   int                 errors;
   int                 pending;

   int                 send_idle_pct = 35;
   int                 recv_idle_pct = 86;
   logic [15:0]        near_mm = '0;
   int                 quiet_cycles = 0;

   drive_safety_stop_monitor uut (.*);
   stop_monitor_checker checker_i (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock)
      rsp_ready = ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_item(req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_cmd = it.cmd;
      req_left_wheel_speed = it.left_wheel_speed;
      req_right_wheel_speed = it.right_wheel_speed;
      req_left_drive = it.left_drive;
      req_right_drive = it.right_drive;
      req_range_mm = it.range_mm;
      req_lost_track = it.lost_track;
      req_on_zebra = it.on_zebra;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off the sender until every status beat is back
   task automatic wait_idle();
      do begin
         @(negedge clock);
         req_valid = 1'b0;
      end while (pending != 0);
   endtask

   task automatic write_csr(logic [1:0] index, logic [15:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_OBSTACLE_THRESHOLD)
         near_mm = data;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // {speed, drive} for one wheel, stalled or not
   function automatic logic [31:0] wheel_pair(bit stall_it);
      logic signed [15:0] spd, drv;
      int unsigned        m;
      spd = 16'($urandom);
      drv = 16'($urandom);
      if (stall_it) begin
         spd = -16'($urandom_range(32768, 0));
         m = $urandom_range(32768, 1001);
         drv = $urandom_range(1) ? 16'(m) : -16'(m);
      end else if ($urandom_range(1)) begin
         spd = 16'($urandom_range(32767, 1));
      end else begin
         drv = 16'($urandom_range(2000)) - 16'd1000;
      end
      // values right at the stall compare points
      if ($urandom_range(99) < 15) begin
         case ($urandom_range(4))
            0:       spd = 16'sd0;
            1:       spd = 16'sd1;
            2:       spd = -16'sd1;
            3:       spd = 16'sh8000;
            default: spd = 16'sh7FFF;
         endcase
         case ($urandom_range(3))
            0:       drv = STALL_DRIVE_POS;
            1:       drv = STALL_DRIVE_POS + 16'sd1;
            2:       drv = STALL_DRIVE_NEG;
            default: drv = STALL_DRIVE_NEG - 16'sd1;
         endcase
      end
      return {spd, drv};
   endfunction

   function automatic req_item_type make_tick(int start_pct, int near_pct, int lost_pct,
                                              int stall_pct, int zebra_pct);
      req_item_type it;
      logic [31:0]  lw, rw;
      lw = wheel_pair($urandom_range(99) < stall_pct);
      rw = wheel_pair($urandom_range(99) < stall_pct);
      it.cmd = ($urandom_range(99) < start_pct);
      it.left_wheel_speed = lw[31:16];
      it.left_drive = lw[15:0];
      it.right_wheel_speed = rw[31:16];
      it.right_drive = rw[15:0];
      if ($urandom_range(99) < 10)
         it.range_mm = 16'($urandom);
      else if ($urandom_range(99) < near_pct && near_mm != 16'd0)
         it.range_mm = 16'($urandom_range(near_mm - 16'd1, 0));
      else
         it.range_mm = 16'($urandom_range(16'hFFFF, near_mm));
      it.lost_track = ($urandom_range(99) < lost_pct);
      it.on_zebra = ($urandom_range(99) < zebra_pct);
      return it;
   endfunction

   function automatic int pick_level();
      case ($urandom_range(2))
         0:       return 0;
         1:       return 40;
         default: return 95;
      endcase
   endfunction

   task automatic reconfigure();
      logic [15:0] lim;
      wait_idle();
      case ($urandom_range(7))
         0:       lim = 16'd0;
         1:       lim = 16'd1;
         2:       lim = TIME_LIMIT_MAX - 16'd1;
         3:       lim = TIME_LIMIT_MAX;
         4:       lim = 16'hFFFF;
         5:       lim = 16'($urandom);
         default: lim = 16'($urandom_range(60, 2));
      endcase
      if ($urandom_range(3) != 0)
         write_csr(CSR_RUN_TIME_LIMIT, lim);
      if ($urandom_range(3) != 0) begin
         case ($urandom_range(3))
            0:       write_csr(CSR_OBSTACLE_THRESHOLD, 16'd0);
            1:       write_csr(CSR_OBSTACLE_THRESHOLD, 16'hFFFF);
            default: write_csr(CSR_OBSTACLE_THRESHOLD, 16'($urandom));
         endcase
      end
      if ($urandom_range(3) != 0)
         write_csr(CSR_TRACK_CHECK_ENABLE, 16'($urandom));
      if ($urandom_range(15) == 0)
         write_csr(CSR_UNUSED, 16'($urandom));
   endtask

   // start, then a run of ticks with a fault mix that holds for the whole run
   task automatic run_episodes(int budget);
      int           sent, len, near_pct, lost_pct, stall_pct;
      req_item_type it;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(1) == 0)
            reconfigure();
         it = make_tick(0, 50, 50, 50, 50);
         it.cmd = 1'b1;
         send_item(it);
         near_pct = pick_level();
         lost_pct = pick_level();
         stall_pct = pick_level();
         len = $urandom_range(80, 10);
         repeat (len)
            send_item(make_tick(2, near_pct, lost_pct, stall_pct, 10));
         sent += len + 1;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // field extremes while stopped, double start, extremes while running
      send_item('{1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 1'b1, 1'b1});
      send_item('{1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b0, 1'b0});
      send_item('{1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b1});
      send_item('{1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 1'b0, 1'b0});
      send_item('{1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 1'b1, 1'b1});
      send_item('{1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b0});

      // shortest time limit: timed stop while obstacle and track counters move
      wait_idle();
      write_csr(CSR_RUN_TIME_LIMIT, 16'd1);
      write_csr(CSR_OBSTACLE_THRESHOLD, 16'hFFFF);
      write_csr(CSR_TRACK_CHECK_ENABLE, 16'hFFFF);
      send_item('{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b0, 1'b0});
      send_item('{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b0, 1'b0});
      send_item('{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 1'b1, 1'b0});
      send_item('{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 1'b1, 1'b0});
      send_item('{1'b1, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'h1234, 1'b0, 1'b1});
      send_item('{1'b0, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'h1234, 1'b1, 1'b1});
      send_item('{1'b0, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'h1234, 1'b1, 1'b1});

      // limit off, threshold 1, track check off with upper data bits set
      wait_idle();
      write_csr(CSR_RUN_TIME_LIMIT, 16'hFFFF);
      write_csr(CSR_OBSTACLE_THRESHOLD, 16'd1);
      write_csr(CSR_TRACK_CHECK_ENABLE, 16'hFFFE);
      send_item('{1'b1, 16'sd1, 16'sd1, 16'sd1000, 16'sd1001, 16'h0001, 1'b1, 1'b0});
      send_item('{1'b0, 16'sd0, 16'sd1, -16'sd1001, -16'sd1000, 16'h0000, 1'b1, 1'b0});
      send_item('{1'b0, -16'sd1, 16'sd0, 16'sd1001, -16'sd1001, 16'h0001, 1'b0, 1'b1});
      send_item('{1'b0, 16'sd1, -16'sd1, -16'sd1000, 16'sd1000, 16'h0000, 1'b1, 1'b0});
      wait_idle();
      write_csr(CSR_UNUSED, 16'($urandom));

      run_episodes(25);
      wait_idle();
      send_idle_pct = 86;
      recv_idle_pct = 35;
      run_episodes(25);
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_episodes(25);

      // obstacle and lost-track counters climb together until one of them trips
      wait_idle();
      write_csr(CSR_RUN_TIME_LIMIT, 16'd0);
      write_csr(CSR_OBSTACLE_THRESHOLD, 16'hFFFF);
      write_csr(CSR_TRACK_CHECK_ENABLE, 16'd1);
      send_item('{1'b1, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'h0000, 1'b1, 1'b0});
      repeat (102)
         send_item('{1'b0, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'h0000, 1'b1, 1'b0});

      // long run past the stall arming point until the stall counter trips
      wait_idle();
      write_csr(CSR_OBSTACLE_THRESHOLD, 16'd0);
      write_csr(CSR_TRACK_CHECK_ENABLE, 16'd0);
      send_item('{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0});
      repeat (1215)
         send_item(make_tick(0, 0, 0, 100, 0));

      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dssm_pkg.sv
rtl/dssm_in_stage.sv
rtl/dssm_step.sv
rtl/dssm_out_stage.sv
rtl/drive_safety_stop_monitor.sv
rtl/dssm_checker.sv
test/stop_monitor_checker.sv
test/drive_safety_stop_monitor_tb.sv
